// ===== rtl/rect_fill_copy_blitter_defines.svh =====
// Assertion helpers for the blitter
`ifndef RECT_FILL_COPY_BLITTER_DEFINES_SVH
`define RECT_FILL_COPY_BLITTER_DEFINES_SVH

`define RFCB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define RFCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/rfcb_pkg.sv =====
package rfcb_pkg;
	localparam int MaxWidth  = 256;
	localparam int MaxHeight = 256;
	localparam int AddrW     = $clog2(MaxWidth * MaxHeight);
	localparam int DimW      = 9;

	localparam logic [2:0] KIND_FILL  = 3'd0;
	localparam logic [2:0] KIND_COPY  = 3'd1;
	localparam logic [2:0] KIND_BSTART = 3'd2;
	localparam logic [2:0] KIND_BPIX  = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OOB   = 2'd1;
	localparam logic [1:0] ST_PSIZE = 2'd2;
	localparam logic [1:0] ST_NOBMP = 2'd3;

	localparam logic [1:0] REG_FW = 2'd0;
	localparam logic [1:0] REG_FH = 2'd1;
	localparam logic [1:0] REG_PB = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] x_pos;
		logic [15:0] y_pos;
		logic [15:0] rect_width;
		logic [15:0] rect_height;
		logic [15:0] dest_x_pos;
		logic [15:0] dest_y_pos;
		logic [31:0] pixel_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] read_value;
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic             we;
		logic [AddrW-1:0] waddr;
		logic             wsel_rd;  // write data from read port
		logic [31:0]      wdata;
		logic [AddrW-1:0] raddr;
	} dp_cmd_t;

	function automatic logic [31:0] pix_mask(input logic [2:0] pb);
		logic [31:0] m;
		m = '0;
		case (pb)
			3'd0: m = 32'h0000_0000;
			3'd1: m = 32'h0000_00ff;
			3'd2: m = 32'h0000_ffff;
			3'd3: m = 32'h00ff_ffff;
			default: m = 32'hffff_ffff;
		endcase
		return m;
	endfunction
endpackage

// ===== rtl/rfcb_if.sv =====
interface rfcb_cmd_if;
	import rfcb_pkg::*;
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rfcb_res_if;
	import rfcb_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rfcb_ram.sv =====
module rfcb_ram #(
	parameter int Width = 32,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/rfcb_datapath.sv =====
module rfcb_datapath (
	input  logic                               clk,
	input  rfcb_pkg::dp_cmd_t                  cmd,
	output logic [31:0]                        rdata
);
	import rfcb_pkg::*;

	logic [31:0] wdata;

	assign wdata = cmd.wsel_rd ? rdata : cmd.wdata;

	rfcb_ram #(.Width(32), .Depth(MaxWidth * MaxHeight)) u_ram (
		.clk  (clk),
		.we   (cmd.we),
		.waddr(cmd.waddr),
		.wdata(wdata),
		.raddr(cmd.raddr),
		.rdata(rdata)
	);
endmodule

// ===== rtl/rfcb_ctrl.sv =====
module rfcb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	rfcb_cmd_if.sink             cmd_in,
	rfcb_res_if.source           res_out,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [8:0]           cfg_data,
	output rfcb_pkg::dp_cmd_t    dp,
	input  logic [31:0]          rdata,
	output logic                 idle
);
	import rfcb_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_FILL  = 3'd2;
	localparam logic [2:0] S_CRD   = 3'd3;
	localparam logic [2:0] S_CWR   = 3'd4;
	localparam logic [2:0] S_RD    = 3'd5;

	logic [2:0] state_q;
	logic [AddrW-1:0] clr_q;
	logic [8:0] fw_q, fh_q;
	logic [2:0] pb_q;
	logic [8:0] bl_q, bt_q, bc_q, br_q, cc_q, cr_q;
	logic bopen_q;
	// walk registers
	logic [8:0] col_q, row_q, w_q, h_q, sx_q, sy_q, dx_q, dy_q;
	logic rev_q;
	logic rev_col_q;
	logic [31:0] val_q;
	logic res_valid_q;
	res_t res_q;
	logic [31:0] rmask_q;

	logic [8:0] ew, eh;
	assign ew = (fw_q > 9'(MaxWidth)) ? 9'(MaxWidth) : fw_q;
	assign eh = (fh_q > 9'(MaxHeight)) ? 9'(MaxHeight) : fh_q;

	cmd_t c;
	assign c = cmd_in.data;

	logic src_ok, dst_ok, rd_ok, pb_ok;
	assign src_ok = ({1'b0, c.x_pos} + {1'b0, c.rect_width} <= {8'd0, ew})
		&& ({1'b0, c.y_pos} + {1'b0, c.rect_height} <= {8'd0, eh});
	assign dst_ok = ({1'b0, c.dest_x_pos} + {1'b0, c.rect_width} <= {8'd0, ew})
		&& ({1'b0, c.dest_y_pos} + {1'b0, c.rect_height} <= {8'd0, eh});
	assign rd_ok = (c.x_pos < {7'd0, ew}) && (c.y_pos < {7'd0, eh});
	assign pb_ok = (pb_q == 3'd1) || (pb_q == 3'd2) || (pb_q == 3'd4);

	logic idle_ready, accept, out_free;
	assign out_free = !res_valid_q || res_out.ready;
	assign idle_ready = (state_q == S_IDLE) && out_free;
	assign cmd_in.ready = idle_ready;
	assign accept = cmd_in.valid && idle_ready;
	assign res_out.valid = res_valid_q;
	assign res_out.data = res_q;
	assign idle = (state_q == S_IDLE);

	// address = row * width + col; full 17-bit product, kept if inside store
	function automatic logic [17:0] mk_addr(input logic [8:0] col, input logic [8:0] row,
		input logic [8:0] wd);
		return 18'({9'd0, row} * {9'd0, wd}) + 18'(col);
	endfunction

	logic [8:0] bx, by;
	logic [17:0] bpa, rda, fa, sa, da;
	assign bx = bl_q + cc_q;
	assign by = bt_q + cr_q;
	assign bpa = mk_addr(bx, by, ew);
	assign rda = mk_addr(c.x_pos[8:0], c.y_pos[8:0], ew);
	assign fa = mk_addr(sx_q + col_q, sy_q + row_q, ew);
	logic [8:0] crow, ccol;
	assign crow = rev_q ? (h_q - 9'd1 - row_q) : row_q;
	// same-row copy to the right walks columns from the right end
	assign ccol = rev_col_q ? (w_q - 9'd1 - col_q) : col_q;
	assign sa = mk_addr(sx_q + ccol, sy_q + crow, ew);
	assign da = mk_addr(dx_q + ccol, dy_q + crow, ew);

	logic last_col, last_row;
	assign last_col = (col_q == w_q - 9'd1);
	assign last_row = (row_q == h_q - 9'd1);

	localparam logic [17:0] Depth = 18'(MaxWidth * MaxHeight);

	always_comb begin
		dp = '0;
		unique case (state_q)
			S_CLEAR: begin
				dp.we = 1'b1;
				dp.waddr = clr_q;
			end
			S_IDLE: begin
				if (accept && c.kind == KIND_BPIX && bopen_q && bpa < Depth) begin
					dp.we = 1'b1;
					dp.waddr = AddrW'(bpa);
					dp.wdata = c.pixel_value & pix_mask(pb_q);
				end
				dp.raddr = AddrW'(rda);
			end
			S_FILL: begin
				dp.we = fa < Depth;
				dp.waddr = AddrW'(fa);
				dp.wdata = val_q;
			end
			S_CRD: dp.raddr = AddrW'(sa);
			S_CWR: begin
				dp.we = 1'b1;
				dp.waddr = AddrW'(da);
				dp.wsel_rd = 1'b1;
			end
			S_RD: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			fw_q <= 9'd256; fh_q <= 9'd256; pb_q <= 3'd4;
			bopen_q <= 1'b0;
			bl_q <= '0; bt_q <= '0; bc_q <= '0; br_q <= '0; cc_q <= '0; cr_q <= '0;
			res_valid_q <= 1'b0;
			col_q <= '0; row_q <= '0;
		end else begin
			if (res_valid_q && res_out.ready)
				res_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FW: begin fw_q <= cfg_data; bopen_q <= 1'b0; end
					REG_FH: begin fh_q <= cfg_data; bopen_q <= 1'b0; end
					REG_PB: pb_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q)
						state_q <= S_IDLE;
				end
				S_IDLE: if (accept) begin
					res_q <= '{status: ST_OK, read_value: 32'd0};
					col_q <= '0; row_q <= '0;
					w_q <= c.rect_width[8:0]; h_q <= c.rect_height[8:0];
					sx_q <= c.x_pos[8:0]; sy_q <= c.y_pos[8:0];
					dx_q <= c.dest_x_pos[8:0]; dy_q <= c.dest_y_pos[8:0];
					rev_q <= c.dest_y_pos > c.y_pos;
					rev_col_q <= (c.dest_y_pos == c.y_pos) && (c.dest_x_pos > c.x_pos);
					val_q <= c.pixel_value & pix_mask(pb_q);
					res_valid_q <= 1'b1;
					case (c.kind)
						KIND_FILL: begin
							if (!src_ok) res_q.status <= ST_OOB;
							else if (!pb_ok) res_q.status <= ST_PSIZE;
							else if (c.rect_width != 0 && c.rect_height != 0) begin
								state_q <= S_FILL;
								res_valid_q <= 1'b0;
							end
						end
						KIND_COPY: begin
							if (!src_ok || !dst_ok) res_q.status <= ST_OOB;
							else if (c.rect_width != 0 && c.rect_height != 0) begin
								state_q <= S_CRD;
								res_valid_q <= 1'b0;
							end
						end
						KIND_BSTART: begin
							if (!src_ok) begin
								res_q.status <= ST_OOB;
								bopen_q <= 1'b0;
							end else begin
								bl_q <= c.x_pos[8:0]; bt_q <= c.y_pos[8:0];
								bc_q <= c.rect_width[8:0]; br_q <= c.rect_height[8:0];
								cc_q <= '0; cr_q <= '0;
								bopen_q <= c.rect_width != 0 && c.rect_height != 0;
							end
						end
						KIND_BPIX: begin
							if (!bopen_q) res_q.status <= ST_NOBMP;
							else if (cc_q + 9'd1 >= bc_q) begin
								cc_q <= '0;
								cr_q <= cr_q + 9'd1;
								if (cr_q + 9'd1 >= br_q) bopen_q <= 1'b0;
							end else
								cc_q <= cc_q + 9'd1;
						end
						KIND_READ: begin
							if (!rd_ok) res_q.status <= ST_OOB;
							else begin
								state_q <= S_RD;
								res_valid_q <= 1'b0;
								rmask_q <= pix_mask(pb_q);
							end
						end
						default: ;
					endcase
				end
				S_RD: begin
					res_q.read_value <= rdata & rmask_q;
					res_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_FILL, S_CWR: begin
					if (last_col) begin
						col_q <= '0;
						row_q <= row_q + 9'd1;
						if (last_row) begin
							res_valid_q <= 1'b1;
							state_q <= S_IDLE;
						end else
							state_q <= (state_q == S_CWR) ? S_CRD : S_FILL;
					end else begin
						col_q <= col_q + 9'd1;
						state_q <= (state_q == S_CWR) ? S_CRD : S_FILL;
					end
				end
				S_CRD: state_q <= S_CWR;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/rect_fill_copy_blitter.sv =====
// channel | dir | handshake    | word
// cmd     | in  | valid/ready  | cmd_t (kind, rectangle, pixel_value)
// res     | out | valid/ready  | res_t (status, read_value)
// Reset clears the store, writing every word in turn; cmd.ready stays low until it is done.
// Bitmap pixel, bitmap start and reject items are answered from idle; a read passes through S_RD (RAM read).
// Fill writes each pixel in S_FILL; copy reads then writes each pixel (S_CRD then S_CWR).
// A held result word stalls the next command until taken.
`include "rect_fill_copy_blitter_defines.svh"
module rect_fill_copy_blitter (
	input  logic        clk,
	input  logic        arst_n,
	rfcb_cmd_if.sink    cmd,
	rfcb_res_if.source  res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);
	import rfcb_pkg::*;

	dp_cmd_t dp;
	logic [31:0] rdata;
	logic idle;

	rfcb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cmd_in(cmd), .res_out(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.dp(dp), .rdata(rdata), .idle(idle)
	);

	rfcb_datapath u_dp (.clk(clk), .cmd(dp), .rdata(rdata));

	`RFCB_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, cmd.ready, idle)
	`RFCB_ASSERT_NEXT(a_res_held, clk, arst_n, res.valid && !res.ready, res.valid && $stable(res.data))
	`RFCB_ASSERT_IMPL(a_ready_free, clk, arst_n, cmd.ready, !res.valid || res.ready)
endmodule

// ===== tb/rect_fill_copy_blitter_test.sv =====
`timescale 1ns / 1ps

module rect_fill_copy_blitter_test;
	import rfcb_pkg::*;

	localparam logic [1:0] RegSpare = 2'd3;
	localparam int WatchdogLimit = 600000;

	// Mirror of the frame store and bitmap cursor; holds the result words still owed.
	class blit_scoreboard;
		logic [31:0] pixels [0:MaxWidth*MaxHeight-1];
		res_t owed[$];
		int errors;
		int unsigned fw, fh;
		logic [2:0] pb;
		bit bm_open;
		int unsigned bm_left, bm_top, bm_cols, bm_rows, cur_col, cur_row;

		function new();
			foreach (pixels[i]) pixels[i] = '0;
			fw = MaxWidth;
			fh = MaxHeight;
			pb = 3'd4;
			bm_open = 0;
			errors = 0;
		endfunction

		function int unsigned w_eff();
			return (fw > MaxWidth) ? MaxWidth : fw;
		endfunction

		function int unsigned h_eff();
			return (fh > MaxHeight) ? MaxHeight : fh;
		endfunction

		function logic [31:0] mask();
			case (pb)
				3'd0: return 32'h0;
				3'd1: return 32'hff;
				3'd2: return 32'hffff;
				3'd3: return 32'hff_ffff;
				default: return 32'hffff_ffff;
			endcase
		endfunction

		function bit fits(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
			return (x + w <= w_eff()) && (y + h <= h_eff());
		endfunction

		function int unsigned addr(int unsigned x, int unsigned y);
			return y * w_eff() + x;
		endfunction

		function void set_reg(logic [1:0] idx, logic [8:0] v);
			case (idx)
				REG_FW: begin
					fw = 32'(v);
					bm_open = 0;
				end
				REG_FH: begin
					fh = 32'(v);
					bm_open = 0;
				end
				REG_PB: pb = v[2:0];
				default: ;
			endcase
		endfunction

		function void note(cmd_t c);
			res_t r;
			int unsigned x, y, w, h, dx, dy, a, s, d, row;
			logic [31:0] line [0:MaxWidth-1];
			x = 32'(c.x_pos); y = 32'(c.y_pos);
			w = 32'(c.rect_width); h = 32'(c.rect_height);
			dx = 32'(c.dest_x_pos); dy = 32'(c.dest_y_pos);
			r = '0;
			case (c.kind)
				KIND_FILL: begin
					if (!fits(x, y, w, h)) r.status = ST_OOB;
					else if (pb != 1 && pb != 2 && pb != 4) r.status = ST_PSIZE;
					else begin
						for (int i = 0; i < h; i++)
							for (int j = 0; j < w; j++) begin
								a = addr(x + j, y + i);
								if (a < MaxWidth*MaxHeight) pixels[a] = c.pixel_value & mask();
							end
					end
				end
				KIND_COPY: begin
					if (!fits(x, y, w, h) || !fits(dx, dy, w, h)) r.status = ST_OOB;
					else begin
						// row order chosen so overlapping rectangles read before write
						for (int i = 0; i < h; i++) begin
							row = (dy > y) ? (h - 1 - i) : i;
							s = addr(x, y + row);
							d = addr(dx, dy + row);
							if (w > 0 && s + w <= MaxWidth*MaxHeight &&
									d + w <= MaxWidth*MaxHeight) begin
								for (int j = 0; j < w; j++) line[j] = pixels[s + j];
								for (int j = 0; j < w; j++) pixels[d + j] = line[j];
							end
						end
					end
				end
				KIND_BSTART: begin
					if (!fits(x, y, w, h)) begin
						r.status = ST_OOB;
						bm_open = 0;
					end else begin
						bm_left = x; bm_top = y; bm_cols = w; bm_rows = h;
						cur_col = 0; cur_row = 0;
						bm_open = (w != 0 && h != 0);
					end
				end
				KIND_BPIX: begin
					if (!bm_open) r.status = ST_NOBMP;
					else begin
						a = addr(bm_left + cur_col, bm_top + cur_row);
						if (a < MaxWidth*MaxHeight) pixels[a] = c.pixel_value & mask();
						cur_col++;
						if (cur_col >= bm_cols) begin
							cur_col = 0;
							cur_row++;
							if (cur_row >= bm_rows) bm_open = 0;
						end
					end
				end
				KIND_READ: begin
					if (x >= w_eff() || y >= h_eff()) r.status = ST_OOB;
					else begin
						a = addr(x, y);
						if (a < MaxWidth*MaxHeight) r.read_value = pixels[a] & mask();
					end
				end
				default: ;
			endcase
			owed.push_back(r);
		endfunction

		function void check(res_t got);
			res_t want;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result word status=%0d value=%h",
					$time, got.status, got.read_value);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.read_value !== want.read_value) begin
				$display("%0t: read_value expected %h actual %h",
					$time, want.read_value, got.read_value);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;
	bit quiet;
	int stall_left;
	int idle_cycles;
	blit_scoreboard sb;

	rfcb_cmd_if cmd_bus();
	rfcb_res_if res_bus();

	rect_fill_copy_blitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.res(res_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side: random back-pressure
	initial begin
		res_bus.ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (res_bus.valid && res_bus.ready) sb.check(res_bus.data);
			if (stall_left > 0) begin
				stall_left--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_word(cmd_t c);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.data <= c;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		sb.note(c);
	endtask

	task automatic drain();
		cmd_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [8:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.set_reg(idx, v);
		cfg_we <= 1'b0;
	endtask

	task automatic set_frame(logic [8:0] w, logic [8:0] h, logic [8:0] pbv);
		drain();
		write_reg(REG_FW, w);
		write_reg(REG_FH, h);
		write_reg(REG_PB, pbv);
		write_reg(RegSpare, 9'($urandom));
		@(posedge clk);
	endtask

	function automatic cmd_t word_of(logic [2:0] k, int x, int y, int w, int h,
			int dx, int dy, logic [31:0] v);
		cmd_t c;
		c.kind = k;
		c.x_pos = 16'(x); c.y_pos = 16'(y);
		c.rect_width = 16'(w); c.rect_height = 16'(h);
		c.dest_x_pos = 16'(dx); c.dest_y_pos = 16'(dy);
		c.pixel_value = v;
		return c;
	endfunction

	// random rectangle, mostly small and inside the frame, sometimes anywhere
	task automatic rand_rect(output int x, output int y, output int w, output int h);
		int fw, fh;
		fw = sb.w_eff();
		fh = sb.h_eff();
		if ($urandom_range(0, 9) == 0) begin
			x = $urandom_range(0, 65535); y = $urandom_range(0, 65535);
			w = $urandom_range(0, 65535); h = $urandom_range(0, 65535);
		end else begin
			w = $urandom_range(0, (fw < 6) ? fw : 6);
			h = $urandom_range(0, (fh < 5) ? fh : 5);
			x = $urandom_range(0, fw - w);
			y = $urandom_range(0, fh - h);
			if ($urandom_range(0, 11) == 0) w = w + $urandom_range(1, 3);
		end
	endtask

	task automatic random_phase(int n);
		int x, y, w, h, dx, dy, dw, dh, r, k;
		k = 0;
		while (k < n) begin
			r = $urandom_range(0, 99);
			rand_rect(x, y, w, h);
			if (r < 20) begin
				send_word(word_of(KIND_FILL, x, y, w, h, $urandom, $urandom, $urandom));
				k++;
			end else if (r < 38) begin
				rand_rect(dx, dy, dw, dh);
				if ($urandom_range(0, 1)) begin
					dx = x + $urandom_range(0, 2) - 1;
					dy = y + $urandom_range(0, 2) - 1;
					if (dx < 0) dx = 0;
					if (dy < 0) dy = 0;
				end
				send_word(word_of(KIND_COPY, x, y, w, h, dx, dy, $urandom));
				k++;
			end else if (r < 65) begin
				// bitmap start then its pixels, sometimes interleaved with reads or overrun
				if (w > 3) w = 3;
				if (h > 3) h = 3;
				send_word(word_of(KIND_BSTART, x, y, w, h, $urandom, $urandom, $urandom));
				k++;
				repeat (w * h + (($urandom_range(0, 5) == 0) ? 1 : 0)) begin
					if ($urandom_range(0, 19) == 0) begin
						send_word(word_of(KIND_READ, $urandom_range(0, 8), $urandom_range(0, 8),
							$urandom, $urandom, $urandom, $urandom, $urandom));
						k++;
					end
					send_word(word_of(KIND_BPIX, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom));
					k++;
				end
			end else if (r < 93) begin
				if ($urandom_range(0, 7) == 0) begin
					x = $urandom_range(0, 65535);
					y = $urandom_range(0, 65535);
				end else begin
					x = $urandom_range(0, sb.w_eff());
					y = $urandom_range(0, sb.h_eff());
				end
				send_word(word_of(KIND_READ, x, y, $urandom, $urandom, $urandom, $urandom,
					$urandom));
				k++;
			end else begin
				send_word(word_of(3'($urandom_range(3, 7)), $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom));
				k++;
			end
		end
	endtask

	initial begin
		sb = new();
		quiet = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_word(word_of(KIND_READ, 255, 255, 0, 0, 0, 0, 0));
		send_word(word_of(KIND_FILL, 0, 0, 256, 256, 0, 0, 32'hdead_beef));
		send_word(word_of(KIND_READ, 0, 0, 0, 0, 0, 0, 0));
		send_word(word_of(KIND_READ, 255, 255, 0, 0, 0, 0, 0));
		send_word(word_of(KIND_READ, 256, 0, 0, 0, 0, 0, 0));
		send_word(word_of(KIND_FILL, 16'hffff, 0, 2, 1, 0, 0, 1));
		send_word(word_of(KIND_FILL, 256, 256, 0, 0, 0, 0, 1));
		send_word(word_of(KIND_FILL, 10, 10, 4, 4, 0, 0, 32'h1234_5678));
		send_word(word_of(KIND_BSTART, 10, 10, 2, 2, 0, 0, 0));
		repeat (4) send_word(word_of(KIND_BPIX, 0, 0, 0, 0, 0, 0, $urandom));
		send_word(word_of(KIND_BPIX, 0, 0, 0, 0, 0, 0, 32'hffff_ffff));
		send_word(word_of(KIND_COPY, 10, 10, 4, 4, 11, 12, 0));
		send_word(word_of(KIND_COPY, 11, 12, 4, 4, 9, 9, 0));
		send_word(word_of(KIND_COPY, 0, 0, 4, 4, 253, 0, 0));
		send_word(word_of(KIND_READ, 12, 13, 0, 0, 0, 0, 0));
		send_word(word_of(KIND_BSTART, 250, 0, 7, 1, 0, 0, 0));
		send_word(word_of(KIND_BSTART, 3, 3, 0, 2, 0, 0, 0));
		send_word(word_of(KIND_BPIX, 0, 0, 0, 0, 0, 0, 7));
		send_word(word_of(3'd5, 1, 1, 1, 1, 1, 1, 1));
		send_word(word_of(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			32'hffff_ffff));

		set_frame(9'd16, 9'd8, 9'd1);
		random_phase(60);
		set_frame(9'd511, 9'd300, 9'd2);
		quiet = 1;
		random_phase(60);
		quiet = 0;
		set_frame(9'd37, 9'd61, 9'd3);
		random_phase(60);
		set_frame(9'd1, 9'd1, 9'd0);
		random_phase(50);
		set_frame(9'd0, 9'd0, 9'd7);
		random_phase(40);
		set_frame(9'd100, 9'd200, 9'd5);
		random_phase(60);
		set_frame(9'd256, 9'd256, 9'd4);
		random_phase(70);
		set_frame(9'd200, 9'd3, 9'd2);
		random_phase(50);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/rfcb_pkg.sv
rtl/rfcb_if.sv
rtl/rfcb_ram.sv
rtl/rfcb_datapath.sv
rtl/rfcb_ctrl.sv
rtl/rect_fill_copy_blitter.sv
tb/rect_fill_copy_blitter_test.sv
